FILE: sv/cct_pkg.sv
`default_nettype none

package cct_pkg;

   localparam int PRESCALE_WIDTH = 16;
   localparam int TPS_W          = 16;
   localparam int MPT_W          = 10;
   localparam int CSR_DATA_W     = 16;
   localparam int COUNT_W        = 64;
   localparam int PRESC_CMP_W    = (PRESCALE_WIDTH + 1 > TPS_W) ? PRESCALE_WIDTH + 1 : TPS_W;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_MS_PER_TICK      = 1'b1;

   localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;
   localparam logic [MPT_W-1:0] MPT_RESET = 10'd1;

   localparam logic [5:0] SEC_LAST   = 6'd59;
   localparam logic [5:0] MIN_LAST   = 6'd59;
   localparam logic [4:0] HOUR_LAST  = 5'd23;
   localparam logic [4:0] HOUR_NOON  = 5'd12;
   localparam logic [3:0] MONTH_LAST = 4'd12;
   localparam logic [3:0] TWELVE     = 4'd12;

   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB   = 5'd28;

   localparam logic [15:0] YEAR_RESET = 16'd2000;

   // Multiplicative inverse of 25 modulo 2^16 and the largest quotient of a 16-bit multiple.
   localparam logic [15:0] INV25     = 16'd23593;
   localparam logic [15:0] DIV25_MAX = 16'd2621;

   typedef struct packed {
      logic        op;
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  year_day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        leap;
   } cct_item_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  year_day;
      logic [4:0]  hour;
      logic [3:0]  hour_twelve;
      logic        morning;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cct_cal_type;

   typedef struct packed {
      cct_cal_type          cal;
      logic [COUNT_W-1:0]   epoch_seconds;
      logic [COUNT_W-1:0]   epoch_millis;
   } cct_snap_type;

   // A year divisible by 25 maps at or below DIV25_MAX when multiplied by the inverse of 25.
   function automatic logic cct_is_leap(input logic [15:0] y);
      logic [15:0] p;
      logic        div4;
      logic        div16;
      logic        div25;
      p     = 16'(y * INV25);
      div25 = (p <= DIV25_MAX);
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      return div4 && (!div25 || div16);
   endfunction

   function automatic logic [4:0] cct_month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
            d = DAYS_LONG;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            d = DAYS_SHORT;
         end
         4'd2: begin
            d = leap ? DAYS_LEAP : DAYS_FEB;
         end
         default: begin
            d = 5'd0;
         end
      endcase
      return d;
   endfunction

   function automatic logic [3:0] cct_hour_twelve(input logic [4:0] h);
      logic [4:0] t;
      t = (h > HOUR_NOON) ? 5'(h - HOUR_NOON) : h;
      if (t == 5'd0) begin
         t = {1'b0, TWELVE};
      end
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/calendar_clock_tick.sv
// Real-time clock and calendar driven by timer ticks.
// Input channel (req_*): each word is a timer tick (req_op low) or a load of the
// date and time fields (req_op high). Each accepted word yields exactly one result
// word on the rsp_* channel, a snapshot of the calendar and of the seconds and
// milliseconds counts taken after the word has been applied.
// The configuration port (csr_*) sets the ticks per second and the milliseconds
// added per tick; the user must write it only while no word is in flight, and the
// block itself does not enforce this. The word sits in the input register while the
// calendar update runs, and the result register is loaded from it once that is free.
// Throughput is one word per cycle while the receiver takes each result.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; after that req_ready drops until the result
// is taken.
// Synchronous reset sets 2000-01-01 00:00:00, clears both counts and the prescaler,
// restores the register defaults and empties both stages.
`default_nettype none

module calendar_clock_tick
   import cct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [15:0]           req_load_year,
   input  wire logic [3:0]            req_load_month,
   input  wire logic [4:0]            req_load_day,
   input  wire logic [8:0]            req_load_year_day,
   input  wire logic [4:0]            req_load_hour,
   input  wire logic [5:0]            req_load_minute,
   input  wire logic [5:0]            req_load_second,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_year,
   output logic [3:0]                 rsp_month,
   output logic [4:0]                 rsp_day,
   output logic [8:0]                 rsp_year_day,
   output logic [4:0]                 rsp_hour,
   output logic [3:0]                 rsp_hour_twelve,
   output logic                       rsp_is_morning,
   output logic [5:0]                 rsp_minute,
   output logic [5:0]                 rsp_second,
   output logic [COUNT_W-1:0]         rsp_epoch_seconds,
   output logic [COUNT_W-1:0]         rsp_epoch_millis
);

   cct_item_type req_item;
   cct_item_type s1_item;
   logic         s1_valid;
   logic         take;
   cct_snap_type snap;

   always_comb begin
      req_item          = '0;
      req_item.op       = req_op;
      req_item.year     = req_load_year;
      req_item.month    = req_load_month;
      req_item.day      = req_load_day;
      req_item.year_day = req_load_year_day;
      req_item.hour     = req_load_hour;
      req_item.minute   = req_load_minute;
      req_item.second   = req_load_second;
   end

   cct_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .take      (take),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item)
   );

   cct_calendar_core u_calendar_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_snap  (snap)
   );

   assign rsp_year          = snap.cal.year;
   assign rsp_month         = snap.cal.month;
   assign rsp_day           = snap.cal.day;
   assign rsp_year_day      = snap.cal.year_day;
   assign rsp_hour          = snap.cal.hour;
   assign rsp_hour_twelve   = snap.cal.hour_twelve;
   assign rsp_is_morning    = snap.cal.morning;
   assign rsp_minute        = snap.cal.minute;
   assign rsp_second        = snap.cal.second;
   assign rsp_epoch_seconds = snap.epoch_seconds;
   assign rsp_epoch_millis  = snap.epoch_millis;

endmodule

`default_nettype wire

FILE: sv/cct_input_stage.sv
`default_nettype none

module cct_input_stage
   import cct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire cct_item_type req_item,
   input  wire logic         take,
   output logic              s1_valid,
   output cct_item_type      s1_item
);

   logic         valid_ff;
   logic         valid_in;
   cct_item_type item_ff;
   cct_item_type item_in;
   logic         accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
      item_in      = req_item;
      item_in.leap = cct_is_leap(req_item.year);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

`default_nettype wire

FILE: sv/cct_calendar_core.sv
`default_nettype none

module cct_calendar_core
   import cct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  s1_valid,
   input  wire cct_item_type          s1_item,
   output logic                       take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output cct_snap_type               rsp_snap
);

   logic [TPS_W-1:0]          tps_ff;
   logic [MPT_W-1:0]          mpt_ff;
   cct_cal_type               cal_ff;
   cct_cal_type               cal_in;
   logic [COUNT_W-1:0]        sec_cnt_ff;
   logic [COUNT_W-1:0]        sec_cnt_in;
   logic [COUNT_W-1:0]        ms_ff;
   logic [COUNT_W-1:0]        ms_in;
   logic [PRESCALE_WIDTH-1:0] presc_ff;
   logic [PRESCALE_WIDTH-1:0] presc_in;
   logic                      leap_ff;
   logic                      leap_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   cct_snap_type              snap_ff;
   logic [PRESC_CMP_W-1:0]    presc_next;
   logic [PRESC_CMP_W-1:0]    rate;
   logic [4:0]                days;
   logic [4:0]                hour_inc;

   assign take = s1_valid && (!out_valid_ff || rsp_ready);

   assign presc_next = PRESC_CMP_W'(presc_ff) + PRESC_CMP_W'(1);
   assign rate       = (tps_ff == '0) ? PRESC_CMP_W'(1) : PRESC_CMP_W'(tps_ff);
   assign days       = cct_month_days(cal_ff.month, leap_ff);
   assign hour_inc   = 5'(cal_ff.hour + 5'd1);

   always_comb begin
      cal_in     = cal_ff;
      sec_cnt_in = sec_cnt_ff;
      ms_in      = ms_ff;
      presc_in   = presc_ff;
      leap_in    = cct_is_leap(cal_ff.year);
      if (take) begin
         if (s1_item.op == OP_LOAD) begin
            cal_in.year        = s1_item.year;
            cal_in.month       = s1_item.month;
            cal_in.day         = s1_item.day;
            cal_in.year_day    = s1_item.year_day;
            cal_in.hour        = s1_item.hour;
            cal_in.minute      = s1_item.minute;
            cal_in.second      = s1_item.second;
            cal_in.hour_twelve = cct_hour_twelve(s1_item.hour);
            cal_in.morning     = (s1_item.hour < HOUR_NOON);
            leap_in            = s1_item.leap;
         end else begin
            ms_in = ms_ff + COUNT_W'(mpt_ff);
            if (presc_ff == '0) begin
               sec_cnt_in = sec_cnt_ff + COUNT_W'(1);
               if (cal_ff.second < SEC_LAST) begin
                  cal_in.second = 6'(cal_ff.second + 6'd1);
               end else if (cal_ff.minute < MIN_LAST) begin
                  cal_in.second = 6'd0;
                  cal_in.minute = 6'(cal_ff.minute + 6'd1);
               end else if (cal_ff.hour < HOUR_LAST) begin
                  cal_in.second      = 6'd0;
                  cal_in.minute      = 6'd0;
                  cal_in.hour        = hour_inc;
                  cal_in.hour_twelve = cct_hour_twelve(hour_inc);
                  cal_in.morning     = (hour_inc < HOUR_NOON);
               end else begin
                  cal_in.second      = 6'd0;
                  cal_in.minute      = 6'd0;
                  cal_in.hour        = 5'd0;
                  cal_in.hour_twelve = TWELVE;
                  cal_in.morning     = 1'b1;
                  if (cal_ff.day < days) begin
                     cal_in.day      = 5'(cal_ff.day + 5'd1);
                     cal_in.year_day = 9'(cal_ff.year_day + 9'd1);
                  end else if (cal_ff.month < MONTH_LAST) begin
                     cal_in.day      = 5'd1;
                     cal_in.month    = 4'(cal_ff.month + 4'd1);
                     cal_in.year_day = 9'(cal_ff.year_day + 9'd1);
                  end else begin
                     cal_in.day      = 5'd1;
                     cal_in.month    = 4'd1;
                     cal_in.year_day = 9'd1;
                     cal_in.year     = 16'(cal_ff.year + 16'd1);
                  end
               end
               if (cal_in.hour_twelve == 4'd0) begin
                  cal_in.hour_twelve = TWELVE;
               end
            end
            presc_in = (presc_next >= rate) ? '0 : presc_next[PRESCALE_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff               <= TPS_RESET;
         mpt_ff               <= MPT_RESET;
         cal_ff.year          <= YEAR_RESET;
         cal_ff.month         <= 4'd1;
         cal_ff.day           <= 5'd1;
         cal_ff.year_day      <= 9'd1;
         cal_ff.hour          <= 5'd0;
         cal_ff.hour_twelve   <= TWELVE;
         cal_ff.morning       <= 1'b1;
         cal_ff.minute        <= 6'd0;
         cal_ff.second        <= 6'd0;
         sec_cnt_ff           <= '0;
         ms_ff                <= '0;
         presc_ff             <= '0;
         leap_ff              <= 1'b1;
         out_valid_ff         <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TICKS_PER_SECOND: begin
                  tps_ff <= csr_wdata[TPS_W-1:0];
               end
               CSR_MS_PER_TICK: begin
                  mpt_ff <= csr_wdata[MPT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         cal_ff       <= cal_in;
         sec_cnt_ff   <= sec_cnt_in;
         ms_ff        <= ms_in;
         presc_ff     <= presc_in;
         leap_ff      <= leap_in;
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         snap_ff.cal           <= cal_in;
         snap_ff.epoch_seconds <= sec_cnt_in;
         snap_ff.epoch_millis  <= ms_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_snap  = snap_ff;

   a_second_counted: assert property (@(posedge clock) disable iff (reset)
      take && s1_item.op == OP_TICK && presc_ff == '0
      |=> sec_cnt_ff == $past(sec_cnt_ff) + COUNT_W'(1))
      else $error("seconds count did not advance on a second tick");

   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(sec_cnt_ff) && $stable(ms_ff) && $stable(cal_ff))
      else $error("clock state changed without a word");

   a_load_leap: assert property (@(posedge clock) disable iff (reset)
      take && s1_item.op == OP_LOAD |=> leap_ff == $past(s1_item.leap))
      else $error("leap flag not taken from the loaded year");

   a_snap_matches: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff && snap_ff.epoch_millis == ms_ff
               && snap_ff.epoch_seconds == sec_cnt_ff)
      else $error("result word does not match the counters");

endmodule

`default_nettype wire

FILE: verif/tb_calendar_clock_tick.sv
`default_nettype none

module tb_calendar_clock_tick
   import cct_pkg::*;
;

   typedef struct packed {
      logic        op;
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  year_day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } req_word_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  year_day;
      logic [4:0]  hour;
      logic [3:0]  hour_twelve;
      logic        morning;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [63:0] epoch_s;
      logic [63:0] epoch_ms;
   } clock_view_type;

   class tick_scoreboard;
      bit [15:0]      rate_reg;
      bit [9:0]       step_reg;
      bit [15:0]      presc;
      clock_view_type now;
      clock_view_type snapshots_q[$];
      int unsigned    errors;

      function new();
         rate_reg = TPS_RESET;
         step_reg = MPT_RESET;
         presc = '0;
         now = '0;
         now.year = 16'd2000;
         now.month = 4'd1;
         now.day = 5'd1;
         now.year_day = 9'd1;
         now.hour_twelve = 4'd12;
         now.morning = 1'b1;
         errors = 0;
      endfunction

      function void set_reg(logic idx, bit [15:0] data);
         if (idx == CSR_TICKS_PER_SECOND) begin
            rate_reg = data;
         end else begin
            step_reg = data[9:0];
         end
      endfunction

      function bit leap_year(bit [15:0] y);
         if (y % 400 == 0) begin
            return 1'b1;
         end
         return (y % 100 != 0) && (y % 4 == 0);
      endfunction

      function bit [4:0] days_in(bit [3:0] m, bit [15:0] y);
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
               return 5'd31;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
               return 5'd30;
            end
            4'd2: begin
               return leap_year(y) ? 5'd29 : 5'd28;
            end
            default: begin
               return 5'd0;
            end
         endcase
      endfunction

      function void show_hour();
         bit [4:0] t;
         t = (now.hour > 5'd12) ? now.hour - 5'd12 : now.hour;
         if (t == 5'd0) begin
            t = 5'd12;
         end
         now.hour_twelve = t[3:0];
         now.morning = (now.hour < 5'd12);
      endfunction

      function void next_second();
         if (now.second < 6'd59) begin
            now.second = now.second + 6'd1;
         end else if (now.minute < 6'd59) begin
            now.second = '0;
            now.minute = now.minute + 6'd1;
         end else if (now.hour < 5'd23) begin
            now.second = '0;
            now.minute = '0;
            now.hour = now.hour + 5'd1;
            show_hour();
         end else begin
            now.second = '0;
            now.minute = '0;
            now.hour = '0;
            now.hour_twelve = 4'd12;
            now.morning = 1'b1;
            if (now.day < days_in(now.month, now.year)) begin
               now.day = now.day + 5'd1;
               now.year_day = now.year_day + 9'd1;
            end else if (now.month < 4'd12) begin
               now.day = 5'd1;
               now.month = now.month + 4'd1;
               now.year_day = now.year_day + 9'd1;
            end else begin
               now.day = 5'd1;
               now.month = 4'd1;
               now.year_day = 9'd1;
               now.year = now.year + 16'd1;
            end
         end
         if (now.hour_twelve == 4'd0) begin
            now.hour_twelve = 4'd12;
         end
      endfunction

      function void note_word(req_word_type w);
         bit [16:0] rate;
         bit [16:0] nxt;
         if (w.op == OP_TICK) begin
            now.epoch_ms = now.epoch_ms + 64'(step_reg);
            if (presc == 16'd0) begin
               next_second();
               now.epoch_s = now.epoch_s + 64'd1;
            end
            rate = (rate_reg == 16'd0) ? 17'd1 : {1'b0, rate_reg};
            nxt = {1'b0, presc} + 17'd1;
            presc = (nxt >= rate) ? 16'd0 : nxt[15:0];
         end else begin
            now.year = w.year;
            now.month = w.month;
            now.day = w.day;
            now.year_day = w.year_day;
            now.hour = w.hour;
            now.minute = w.minute;
            now.second = w.second;
            show_hour();
         end
         snapshots_q.push_back(now);
      endfunction

      function void field_check(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR %s: expected %0d, got %0d", name, want, got);
            end
         end
      endfunction

      function void check_word(clock_view_type got);
         clock_view_type want;
         if (snapshots_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR result word arrived with none expected");
            end
            return;
         end
         want = snapshots_q.pop_front();
         field_check("year", 64'(got.year), 64'(want.year));
         field_check("month", 64'(got.month), 64'(want.month));
         field_check("day", 64'(got.day), 64'(want.day));
         field_check("year_day", 64'(got.year_day), 64'(want.year_day));
         field_check("hour", 64'(got.hour), 64'(want.hour));
         field_check("hour_twelve", 64'(got.hour_twelve), 64'(want.hour_twelve));
         field_check("is_morning", 64'(got.morning), 64'(want.morning));
         field_check("minute", 64'(got.minute), 64'(want.minute));
         field_check("second", 64'(got.second), 64'(want.second));
         field_check("epoch_seconds", got.epoch_s, want.epoch_s);
         field_check("epoch_millis", got.epoch_ms, want.epoch_ms);
      endfunction

      function int pending();
         return snapshots_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_op;
   logic [15:0]           req_load_year;
   logic [3:0]            req_load_month;
   logic [4:0]            req_load_day;
   logic [8:0]            req_load_year_day;
   logic [4:0]            req_load_hour;
   logic [5:0]            req_load_minute;
   logic [5:0]            req_load_second;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [15:0]           rsp_year;
   logic [3:0]            rsp_month;
   logic [4:0]            rsp_day;
   logic [8:0]            rsp_year_day;
   logic [4:0]            rsp_hour;
   logic [3:0]            rsp_hour_twelve;
   logic                  rsp_is_morning;
   logic [5:0]            rsp_minute;
   logic [5:0]            rsp_second;
   logic [COUNT_W-1:0]    rsp_epoch_seconds;
   logic [COUNT_W-1:0]    rsp_epoch_millis;

   tick_scoreboard sb = new();
   bit             calm;
   req_word_type   taken;
   clock_view_type seen;

   calendar_clock_tick uut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_load_year     (req_load_year),
      .req_load_month    (req_load_month),
      .req_load_day      (req_load_day),
      .req_load_year_day (req_load_year_day),
      .req_load_hour     (req_load_hour),
      .req_load_minute   (req_load_minute),
      .req_load_second   (req_load_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_year_day      (rsp_year_day),
      .rsp_hour          (rsp_hour),
      .rsp_hour_twelve   (rsp_hour_twelve),
      .rsp_is_morning    (rsp_is_morning),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_epoch_millis  (rsp_epoch_millis)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stretches where neither side idles alternate with stretches of random gaps.
   initial begin
      calm = 1'b0;
      forever begin
         repeat ($urandom_range(100, 400)) @(posedge clock);
         calm = ($urandom_range(0, 3) == 0);
      end
   end

   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            stall_left = pick_pause();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.year = rsp_year;
            seen.month = rsp_month;
            seen.day = rsp_day;
            seen.year_day = rsp_year_day;
            seen.hour = rsp_hour;
            seen.hour_twelve = rsp_hour_twelve;
            seen.morning = rsp_is_morning;
            seen.minute = rsp_minute;
            seen.second = rsp_second;
            seen.epoch_s = rsp_epoch_seconds;
            seen.epoch_ms = rsp_epoch_millis;
            sb.check_word(seen);
         end
         if (req_valid && req_ready) begin
            taken.op = req_op;
            taken.year = req_load_year;
            taken.month = req_load_month;
            taken.day = req_load_day;
            taken.year_day = req_load_year_day;
            taken.hour = req_load_hour;
            taken.minute = req_load_minute;
            taken.second = req_load_second;
            sb.note_word(taken);
         end
      end
   end

   task automatic send_word(req_word_type w);
      int unsigned gap;
      gap = pick_pause();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op = w.op;
      req_load_year = w.year;
      req_load_month = w.month;
      req_load_day = w.day;
      req_load_year_day = w.year_day;
      req_load_hour = w.hour;
      req_load_minute = w.minute;
      req_load_second = w.second;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   task automatic tick_word();
      req_word_type w;
      w = req_word_type'(52'({$urandom, $urandom}));
      w.op = OP_TICK;
      send_word(w);
   endtask

   task automatic load_word(bit [15:0] y, bit [3:0] mo, bit [4:0] d, bit [8:0] yd,
                            bit [4:0] h, bit [5:0] mi, bit [5:0] s);
      req_word_type w;
      w.op = OP_LOAD;
      w.year = y;
      w.month = mo;
      w.day = d;
      w.year_day = yd;
      w.hour = h;
      w.minute = mi;
      w.second = s;
      send_word(w);
   endtask

   task automatic load_near_rollover();
      bit [15:0] y;
      bit [3:0]  mo;
      bit [4:0]  d;
      bit [15:0] years_of_note [8];
      years_of_note = '{16'd1900, 16'd2000, 16'd2100, 16'd2400, 16'd2023, 16'd2024,
                        16'd65535, 16'd0};
      y = ($urandom_range(0, 99) < 40) ? years_of_note[$urandom_range(0, 7)]
                                        : 16'($urandom);
      mo = 4'($urandom_range(1, 12));
      d = sb.days_in(mo, y);
      if ($urandom_range(0, 99) >= 60) begin
         d = 5'($urandom_range(1, d));
      end
      load_word(y, mo, d, 9'($urandom_range(0, 366)),
                ($urandom_range(0, 99) < 60) ? 5'd23 : 5'($urandom_range(0, 23)),
                ($urandom_range(0, 99) < 60) ? 6'd59 : 6'($urandom_range(0, 59)),
                6'($urandom_range(45, 59)));
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, bit [15:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_reg(idx, data);
   endtask

   initial begin
      int        sent;
      int        n;
      int        r;
      bit [15:0] rate_plan [8];
      bit [15:0] step_plan [8];
      rate_plan = '{16'd0, 16'd1, 16'd5, 16'd2, 16'd65535, 16'd1, 16'd3, 16'd1000};
      step_plan = '{16'd1023, 16'd0, 16'd1000, 16'd7, 16'd1, 16'd513, 16'd0, 16'd1};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TICKS_PER_SECOND;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_load_year = '0;
      req_load_month = '0;
      req_load_day = '0;
      req_load_year_day = '0;
      req_load_hour = '0;
      req_load_minute = '0;
      req_load_second = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      tick_word();
      tick_word();
      settle();
      write_reg(CSR_TICKS_PER_SECOND, 16'd1);
      write_reg(CSR_MS_PER_TICK, 16'd1000);
      load_word(16'd1999, 4'd12, 5'd31, 9'd365, 5'd23, 6'd59, 6'd59);
      tick_word();
      load_word(16'd2000, 4'd2, 5'd28, 9'd59, 5'd23, 6'd59, 6'd59);
      tick_word();
      load_word(16'd2100, 4'd2, 5'd28, 9'd59, 5'd23, 6'd59, 6'd59);
      tick_word();
      load_word(16'd2023, 4'd4, 5'd30, 9'd120, 5'd23, 6'd59, 6'd59);
      tick_word();
      load_word(16'd65535, 4'd12, 5'd31, 9'd365, 5'd23, 6'd59, 6'd59);
      tick_word();
      load_word(16'd2024, 4'd6, 5'd15, 9'd167, 5'd11, 6'd59, 6'd59);
      tick_word();
      load_word(16'd2024, 4'd6, 5'd15, 9'd167, 5'd12, 6'd59, 6'd59);
      tick_word();
      load_word(16'd0, 4'd0, 5'd5, 9'd0, 5'd23, 6'd59, 6'd59);
      tick_word();
      load_word(16'd1, 4'd15, 5'd31, 9'd511, 5'd31, 6'd63, 6'd63);
      tick_word();
      load_word(16'd0, 4'd0, 5'd0, 9'd0, 5'd28, 6'd0, 6'd10);
      tick_word();

      for (int p = 0; p < 8; p++) begin
         settle();
         write_reg(CSR_TICKS_PER_SECOND, rate_plan[p]);
         write_reg(CSR_MS_PER_TICK, step_plan[p]);
         sent = 0;
         while (sent < 95) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               load_near_rollover();
               n = $urandom_range(1, 8);
            end else if (r < 85) begin
               load_word(16'($urandom), 4'($urandom), 5'($urandom), 9'($urandom),
                         5'($urandom), 6'($urandom), 6'($urandom));
               n = $urandom_range(1, 3);
            end else begin
               n = $urandom_range(0, 5);
            end
            repeat (n) tick_word();
            sent += n + 1;
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
sv/cct_pkg.sv
sv/cct_input_stage.sv
sv/cct_calendar_core.sv
sv/calendar_clock_tick.sv
verif/tb_calendar_clock_tick.sv
